FILE: sv/chs_pkg.sv
package chs_pkg;

    localparam int MaxWaypoints = 16;
    localparam int MaxJoints    = 6;
    localparam int FracBits     = 16;
    localparam int TableDepth   = MaxWaypoints * MaxJoints;
    localparam int AddrW        = $clog2(TableDepth);

    localparam logic ActLoad   = 1'b0;
    localparam logic ActSample = 1'b1;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StRange   = 2'd1;
    localparam logic [1:0] StInvalid = 2'd2;

    localparam logic [1:0] CfgJointCount    = 2'd0;
    localparam logic [1:0] CfgWaypointCount = 2'd1;
    localparam logic [1:0] CfgSegDuration   = 2'd2;
    localparam logic [1:0] CfgLoopMode      = 2'd3;

    typedef struct packed {
        logic               action;
        logic [3:0]         waypoint_index;
        logic [2:0]         joint_index;
        logic signed [31:0] angle;
        logic signed [31:0] sample_time;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [2:0]         joint;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] acceleration;
        logic               last;
    } result_t;

endpackage

FILE: sv/cubic_hermite_trajectory_sampler.sv
// Cubic Hermite trajectory sampler. A load item writes one Q16.16 joint angle into the
// 16 x 6 waypoint table when its indices lie within the configured counts, and gives its
// single result in the next cycle. A sample item gives one result per joint in use, in
// joint order, each shown for exactly one cycle on result with result_strobe high; the
// receiver cannot stall, so it must take every result as it appears. One 64-step
// restoring divider and one 34 x 22 multiplier do all the work in turn: setup divides for
// segment and phase (after a modulo division in loop mode), then each joint takes one
// division for velocity and two for acceleration, the last skipped if it saturates; a
// sample past the end of an open trajectory skips them and holds the last waypoint at rest.
// busy is high from acceptance of a sample until its last result is out.
// An invalid configuration answers a sample with one status result in the next cycle.
module cubic_hermite_trajectory_sampler (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  chs_pkg::cmd_t    cmd,
    output chs_pkg::result_t result,
    output logic             result_strobe,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    import chs_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_TOTAL = 16'h0002,
        S_RANGE = 16'h0004,
        S_MOD   = 16'h0008,
        S_SEG   = 16'h0010,
        S_PDIV  = 16'h0020,
        S_P2    = 16'h0040,
        S_P3    = 16'h0080,
        S_COEF  = 16'h0100,
        S_READ  = 16'h0200,
        S_MAC   = 16'h0400,
        S_VSET  = 16'h0800,
        S_VDIV  = 16'h1000,
        S_A1    = 16'h2000,
        S_A2    = 16'h4000,
        S_OUT   = 16'h8000
    } state_t;

    localparam int CoefW = 22;
    localparam logic signed [CoefW-1:0] One = CoefW'(1 << FracBits);

    state_t state_reg, state_next;

    logic [2:0]  jc_reg, jc_next;
    logic [4:0]  wc_reg, wc_next;
    logic [31:0] dur_reg, dur_next;
    logic        loop_reg, loop_next;

    logic [30:0] t_reg, t_next;
    logic [35:0] total_reg, total_next;
    logic        hold_reg, hold_next;
    logic [3:0]  seg_reg, seg_next;
    logic [16:0] p_reg, p_next;
    logic [16:0] p2_reg, p2_next;
    logic [16:0] p3_reg, p3_next;
    logic [2:0]  joint_reg, joint_next;
    logic [2:0]  rd_cnt_reg, rd_cnt_next;
    logic [3:0]  mac_cnt_reg, mac_cnt_next;
    logic signed [55:0] prod_reg, prod_next;
    logic signed [63:0] accp_reg, accp_next;
    logic signed [63:0] accv_reg, accv_next;
    logic signed [63:0] acca_reg, acca_next;
    logic [63:0] div_num_reg, div_num_next;
    logic [35:0] div_den_reg, div_den_next;
    logic [35:0] div_rem_reg, div_rem_next;
    logic [5:0]  div_cnt_reg, div_cnt_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] vel_reg, vel_next;
    logic [31:0] accel_reg, accel_next;
    result_t     result_reg, result_next;
    logic        strobe_reg, strobe_next;

    logic signed [31:0]      cell_reg [6];
    logic signed [CoefW-1:0] coef_reg [10];
    logic signed [CoefW-1:0] coef_val [10];

    logic [31:0]       mem [TableDepth];
    logic [TableDepth-1:0] valid_reg;
    logic [31:0]       rd_data_reg;
    logic              rd_valid_reg;
    logic [AddrW-1:0]  rd_addr;
    logic [AddrW-1:0]  wr_addr;
    logic              wr_en;
    logic [3:0]        rd_widx;
    logic [3:0]        nxt_idx;
    logic signed [31:0] rd_cell;

    logic signed [33:0] mul_a;
    logic signed [CoefW-1:0] mul_b;
    logic signed [55:0] mul_p;

    logic [36:0] div_shift;
    logic        div_ge;
    logic [36:0] div_diff;
    logic [35:0] rem_step;
    logic [63:0] quo_step;

    logic signed [33:0] q0_s, q1_s, a0_s, a1_s, dq_s;
    logic signed [63:0] addend;
    logic [3:0]  add_step;
    logic        cfg_bad;
    logic [4:0]  nseg;
    logic [30:0] t_clamp;
    logic [63:0] accv_mag, acca_mag;
    logic signed [63:0] pos_shift;
    logic [63:0] pos_mag;

    function automatic logic [3:0] prev_of(input logic [3:0] idx, input logic lp,
                                           input logic [4:0] wc);
        logic [4:0] wm1;
        wm1 = wc - 5'd1;
        if (idx != 4'd0) return idx - 4'd1;
        return lp ? wm1[3:0] : 4'd0;
    endfunction

    function automatic logic [3:0] next_of(input logic [3:0] idx, input logic lp,
                                           input logic [4:0] wc);
        logic [4:0] inc;
        logic [4:0] wm1;
        inc = {1'b0, idx} + 5'd1;
        wm1 = wc - 5'd1;
        if (inc < wc) return inc[3:0];
        return lp ? 4'd0 : wm1[3:0];
    endfunction

    function automatic logic tan_zero(input logic [3:0] idx, input logic lp,
                                      input logic [4:0] wc);
        return !lp && (idx == 4'd0 || ({1'b0, idx} + 5'd1) >= wc);
    endfunction

    function automatic logic [AddrW-1:0] cell_addr(input logic [3:0] w, input logic [2:0] j);
        return AddrW'(w) * AddrW'(MaxJoints) + AddrW'(j);
    endfunction

    function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
        logic [63:0] n;
        n = ~mag + 64'd1;
        if (neg) return (mag > 64'h8000_0000) ? 32'h8000_0000 : n[31:0];
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    assign busy          = (state_reg != S_IDLE);
    assign result        = result_reg;
    assign result_strobe = strobe_reg;

    assign cfg_bad = (jc_reg == 3'd0) || (jc_reg > 3'(MaxJoints)) || (wc_reg < 5'd2) ||
                     (wc_reg > 5'(MaxWaypoints)) || (dur_reg == 32'd0);
    assign nseg    = loop_reg ? wc_reg : wc_reg - 5'd1;
    assign t_clamp = cmd.sample_time[31] ? 31'd0 : cmd.sample_time[30:0];
    assign nxt_idx = next_of(seg_reg, loop_reg, wc_reg);

    always_comb
    begin
        unique case (rd_cnt_reg)
            3'd1:    rd_widx = nxt_idx;
            3'd2:    rd_widx = prev_of(seg_reg, loop_reg, wc_reg);
            3'd3:    rd_widx = next_of(seg_reg, loop_reg, wc_reg);
            3'd4:    rd_widx = prev_of(nxt_idx, loop_reg, wc_reg);
            3'd5:    rd_widx = next_of(nxt_idx, loop_reg, wc_reg);
            default: rd_widx = seg_reg;
        endcase
    end

    assign rd_addr = cell_addr(rd_widx, joint_reg);
    assign wr_addr = cell_addr(cmd.waypoint_index, cmd.joint_index);
    assign wr_en   = (state_reg == S_IDLE) && start && (cmd.action == ActLoad) &&
                     ({1'b0, cmd.waypoint_index} < wc_reg) &&
                     (cmd.joint_index < jc_reg) && (cmd.joint_index < 3'(MaxJoints));
    assign rd_cell = rd_valid_reg ? rd_data_reg : 32'sd0;

    assign q0_s = 34'(cell_reg[0]);
    assign q1_s = 34'(cell_reg[1]);
    assign dq_s = q0_s - q1_s;
    assign a0_s = tan_zero(seg_reg, loop_reg, wc_reg) ? 34'sd0 :
                  34'(cell_reg[3]) - 34'(cell_reg[2]);
    assign a1_s = tan_zero(nxt_idx, loop_reg, wc_reg) ? 34'sd0 :
                  34'(cell_reg[5]) - 34'(cell_reg[4]);

    always_comb
    begin
        logic signed [CoefW-1:0] ps, p2s, p3s;
        ps  = CoefW'(p_reg);
        p2s = CoefW'(p2_reg);
        p3s = CoefW'(p3_reg);
        coef_val[0] = (p3s <<< 1) - CoefW'(3) * p2s + One;
        coef_val[1] = CoefW'(3) * p2s - (p3s <<< 1);
        coef_val[2] = p3s - (p2s <<< 1) + ps;
        coef_val[3] = p3s - p2s;
        coef_val[4] = CoefW'(6) * p2s - CoefW'(6) * ps;
        coef_val[5] = CoefW'(3) * p2s - (ps <<< 2) + One;
        coef_val[6] = CoefW'(3) * p2s - (ps <<< 1);
        coef_val[7] = CoefW'(12) * ps - CoefW'(6) * One;
        coef_val[8] = CoefW'(6) * ps - (One <<< 2);
        coef_val[9] = CoefW'(6) * ps - (One <<< 1);
    end

    always_comb
    begin
        priority case (1'b1)
            state_reg == S_TOTAL:
            begin
                mul_a = 34'(dur_reg);
                mul_b = CoefW'(nseg);
            end
            state_reg == S_P2:
            begin
                mul_a = 34'(p_reg);
                mul_b = CoefW'(p_reg);
            end
            state_reg == S_P3:
            begin
                mul_a = 34'(p2_reg);
                mul_b = CoefW'(p_reg);
            end
            default:
            begin
                unique case (mac_cnt_reg)
                    4'd0:                   mul_a = q0_s;
                    4'd1:                   mul_a = q1_s;
                    4'd2, 4'd5, 4'd8:       mul_a = a0_s;
                    4'd3, 4'd6, 4'd9:       mul_a = a1_s;
                    4'd4, 4'd7:             mul_a = dq_s;
                    default:                mul_a = 34'sd0;
                endcase
                mul_b = (mac_cnt_reg <= 4'd9) ? coef_reg[mac_cnt_reg] : '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign div_shift = {div_rem_reg, div_num_reg[63]};
    assign div_ge    = div_shift >= {1'b0, div_den_reg};
    assign div_diff  = div_ge ? div_shift - {1'b0, div_den_reg} : div_shift;
    assign rem_step  = div_diff[35:0];
    assign quo_step  = {div_num_reg[62:0], div_ge};

    assign add_step  = mac_cnt_reg - 4'd1;
    assign addend    = (add_step == 4'd0 || add_step == 4'd1 || add_step == 4'd4 ||
                        add_step == 4'd7) ? (64'(prod_reg) <<< 1) : 64'(prod_reg);

    assign accv_mag  = accv_reg[63] ? 64'd0 - 64'(accv_reg) : 64'(accv_reg);
    assign acca_mag  = acca_reg[63] ? 64'd0 - 64'(acca_reg) : 64'(acca_reg);
    assign pos_shift = accp_reg >>> (FracBits + 1);
    assign pos_mag   = pos_shift[63] ? 64'd0 - 64'(pos_shift) : 64'(pos_shift);

    always_comb
    begin
        state_next   = state_reg;
        jc_next      = jc_reg;
        wc_next      = wc_reg;
        dur_next     = dur_reg;
        loop_next    = loop_reg;
        t_next       = t_reg;
        total_next   = total_reg;
        hold_next    = hold_reg;
        seg_next     = seg_reg;
        p_next       = p_reg;
        p2_next      = p2_reg;
        p3_next      = p3_reg;
        joint_next   = joint_reg;
        rd_cnt_next  = rd_cnt_reg;
        mac_cnt_next = mac_cnt_reg;
        prod_next    = prod_reg;
        accp_next    = accp_reg;
        accv_next    = accv_reg;
        acca_next    = acca_reg;
        div_num_next = div_num_reg;
        div_den_next = div_den_reg;
        div_rem_next = div_rem_reg;
        div_cnt_next = div_cnt_reg;
        pos_next     = pos_reg;
        vel_next     = vel_reg;
        accel_next   = accel_reg;
        result_next  = result_reg;
        strobe_next  = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CfgJointCount:    jc_next   = cfg_data[2:0];
                CfgWaypointCount: wc_next   = cfg_data[4:0];
                CfgSegDuration:   dur_next  = cfg_data;
                CfgLoopMode:      loop_next = cfg_data[0];
                default:          ;
            endcase
        end

        if (state_reg == S_MOD || state_reg == S_SEG || state_reg == S_PDIV ||
            state_reg == S_VDIV || state_reg == S_A1 || state_reg == S_A2)
        begin
            div_num_next = quo_step;
            div_rem_next = rem_step;
            div_cnt_next = div_cnt_reg - 6'd1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd.action == ActLoad)
                    begin
                        result_next.status = ({1'b0, cmd.waypoint_index} >= wc_reg) ?
                                             StRange : StOk;
                        result_next.joint        = cmd.joint_index;
                        result_next.position     = '0;
                        result_next.velocity     = '0;
                        result_next.acceleration = '0;
                        result_next.last         = 1'b1;
                        strobe_next              = 1'b1;
                    end
                    else if (cfg_bad)
                    begin
                        result_next.status       = StInvalid;
                        result_next.joint        = '0;
                        result_next.position     = '0;
                        result_next.velocity     = '0;
                        result_next.acceleration = '0;
                        result_next.last         = 1'b1;
                        strobe_next              = 1'b1;
                    end
                    else
                    begin
                        t_next     = t_clamp;
                        hold_next  = 1'b0;
                        state_next = S_TOTAL;
                    end
                end
            end
            S_TOTAL:
            begin
                total_next = mul_p[35:0];
                state_next = S_RANGE;
            end
            S_RANGE:
            begin
                div_rem_next = '0;
                div_cnt_next = 6'd63;
                div_num_next = 64'(t_reg);
                if (loop_reg)
                begin
                    div_den_next = total_reg;
                    state_next   = S_MOD;
                end
                else if (36'(t_reg) >= total_reg)
                begin
                    hold_next   = 1'b1;
                    seg_next    = 4'(wc_reg - 5'd1);
                    joint_next  = '0;
                    rd_cnt_next = '0;
                    state_next  = S_READ;
                end
                else
                begin
                    div_den_next = 36'(dur_reg);
                    state_next   = S_SEG;
                end
            end
            S_MOD:
            begin
                if (div_cnt_reg == 6'd0)
                begin
                    div_num_next = 64'(rem_step[30:0]);
                    div_den_next = 36'(dur_reg);
                    div_rem_next = '0;
                    div_cnt_next = 6'd63;
                    state_next   = S_SEG;
                end
            end
            S_SEG:
            begin
                if (div_cnt_reg == 6'd0)
                begin
                    seg_next     = quo_step[3:0];
                    div_num_next = {16'd0, rem_step[31:0], 16'd0};
                    div_rem_next = '0;
                    div_cnt_next = 6'd63;
                    state_next   = S_PDIV;
                end
            end
            S_PDIV:
            begin
                if (div_cnt_reg == 6'd0)
                begin
                    p_next     = quo_step[16:0];
                    state_next = S_P2;
                end
            end
            S_P2:
            begin
                p2_next    = mul_p[32:16];
                state_next = S_P3;
            end
            S_P3:
            begin
                p3_next    = mul_p[32:16];
                state_next = S_COEF;
            end
            S_COEF:
            begin
                joint_next  = '0;
                rd_cnt_next = '0;
                state_next  = S_READ;
            end
            S_READ:
            begin
                if (rd_cnt_reg == 3'd6)
                begin
                    mac_cnt_next = '0;
                    accp_next    = '0;
                    accv_next    = '0;
                    acca_next    = '0;
                    state_next   = hold_reg ? S_OUT : S_MAC;
                end
                else
                begin
                    rd_cnt_next = rd_cnt_reg + 3'd1;
                end
            end
            S_MAC:
            begin
                prod_next = mul_p;
                if (mac_cnt_reg != 4'd0)
                begin
                    if (add_step <= 4'd3)      accp_next = accp_reg + addend;
                    else if (add_step <= 4'd6) accv_next = accv_reg + addend;
                    else                       acca_next = acca_reg + addend;
                end
                if (mac_cnt_reg == 4'd10) state_next   = S_VSET;
                else                      mac_cnt_next = mac_cnt_reg + 4'd1;
            end
            S_VSET:
            begin
                pos_next     = sat32(pos_shift[63], pos_mag);
                div_num_next = accv_mag;
                div_den_next = {3'd0, dur_reg, 1'b0};
                div_rem_next = '0;
                div_cnt_next = 6'd63;
                state_next   = S_VDIV;
            end
            S_VDIV:
            begin
                if (div_cnt_reg == 6'd0)
                begin
                    vel_next     = sat32(accv_reg[63], quo_step);
                    div_num_next = acca_mag;
                    div_rem_next = '0;
                    div_cnt_next = 6'd63;
                    state_next   = S_A1;
                end
            end
            S_A1:
            begin
                if (div_cnt_reg == 6'd0)
                begin
                    if (quo_step[63:47] != 17'd0)
                    begin
                        accel_next = sat32(acca_reg[63], 64'h4000_0000_0000_0000);
                        state_next = S_OUT;
                    end
                    else
                    begin
                        div_num_next = {quo_step[47:0], 16'd0};
                        div_den_next = 36'(dur_reg);
                        div_rem_next = '0;
                        div_cnt_next = 6'd63;
                        state_next   = S_A2;
                    end
                end
            end
            S_A2:
            begin
                if (div_cnt_reg == 6'd0)
                begin
                    accel_next = sat32(acca_reg[63], quo_step);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                result_next.status       = StOk;
                result_next.joint        = joint_reg;
                result_next.position     = hold_reg ? cell_reg[0] : pos_reg;
                result_next.velocity     = hold_reg ? 32'sd0 : vel_reg;
                result_next.acceleration = hold_reg ? 32'sd0 : accel_reg;
                result_next.last         = (joint_reg == jc_reg - 3'd1);
                strobe_next              = 1'b1;
                if (joint_reg == jc_reg - 3'd1)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    joint_next  = joint_reg + 3'd1;
                    rd_cnt_next = '0;
                    state_next  = S_READ;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cmd.angle;
        end
        rd_data_reg <= mem[rd_addr];
        if (state_reg == S_READ && rd_cnt_reg != 3'd0)
        begin
            cell_reg[rd_cnt_reg - 3'd1] <= rd_cell;
        end
        if (state_reg == S_COEF)
        begin
            coef_reg <= coef_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            jc_reg       <= 3'd6;
            wc_reg       <= 5'd2;
            dur_reg      <= 32'd65536;
            loop_reg     <= 1'b0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            t_reg        <= '0;
            total_reg    <= '0;
            hold_reg     <= 1'b0;
            seg_reg      <= '0;
            p_reg        <= '0;
            p2_reg       <= '0;
            p3_reg       <= '0;
            joint_reg    <= '0;
            rd_cnt_reg   <= '0;
            mac_cnt_reg  <= '0;
            prod_reg     <= '0;
            accp_reg     <= '0;
            accv_reg     <= '0;
            acca_reg     <= '0;
            div_num_reg  <= '0;
            div_den_reg  <= '0;
            div_rem_reg  <= '0;
            div_cnt_reg  <= '0;
            pos_reg      <= '0;
            vel_reg      <= '0;
            accel_reg    <= '0;
            result_reg   <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            jc_reg       <= jc_next;
            wc_reg       <= wc_next;
            dur_reg      <= dur_next;
            loop_reg     <= loop_next;
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
            t_reg        <= t_next;
            total_reg    <= total_next;
            hold_reg     <= hold_next;
            seg_reg      <= seg_next;
            p_reg        <= p_next;
            p2_reg       <= p2_next;
            p3_reg       <= p3_next;
            joint_reg    <= joint_next;
            rd_cnt_reg   <= rd_cnt_next;
            mac_cnt_reg  <= mac_cnt_next;
            prod_reg     <= prod_next;
            accp_reg     <= accp_next;
            accv_reg     <= accv_next;
            acca_reg     <= acca_next;
            div_num_reg  <= div_num_next;
            div_den_reg  <= div_den_next;
            div_rem_reg  <= div_rem_next;
            div_cnt_reg  <= div_cnt_next;
            pos_reg      <= pos_next;
            vel_reg      <= vel_next;
            accel_reg    <= accel_next;
            result_reg   <= result_next;
            strobe_reg   <= strobe_next;
        end
    end

endmodule

FILE: sv/chs_checker.sv
module chs_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input chs_pkg::cmd_t    cmd,
    input chs_pkg::result_t result,
    input logic             result_strobe
);
    import chs_pkg::*;

    a_load_answers: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.action == ActLoad |=> result_strobe && result.last)
        else $error("load item gave no single result");

    a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.action == ActLoad |=>
        result.position == 0 && result.velocity == 0 && result.acceleration == 0)
        else $error("load result carries nonzero motion");

    a_sample_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.action == ActSample |=> busy || result_strobe)
        else $error("sample item dropped");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.status != StOk |-> result.last)
        else $error("error status not on final result");

endmodule

bind cubic_hermite_trajectory_sampler chs_checker u_chs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .result        (result),
    .result_strobe (result_strobe)
);

FILE: test/tb_cubic_hermite_trajectory_sampler.sv
module tb_cubic_hermite_trajectory_sampler;
    import chs_pkg::*;

    localparam longint CycleLimit = 4000000;
    localparam int     Phases     = 10;
    localparam int     PerPhase   = 48;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_index;
        logic [31:0] reg_data;
        cmd_t        item;
        bit          typed;
        result_t     typed_result;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    result_t     result;
    logic        result_strobe;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    logic signed [31:0] angles [MaxWaypoints][MaxJoints];
    logic [2:0]         n_joints;
    logic [4:0]         n_waypoints;
    logic [31:0]        seg_dur;
    logic               loop_on;

    result_t   expected_results [$];
    result_t   fresh_results [$];
    plan_row_t plan [$];

    longint cycles = 0;
    int     errors = 0;
    int     n_loads;
    int     n_samples;
    int     n_checked = 0;
    bit     bursty;

    cubic_hermite_trajectory_sampler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result       (result),
        .result_strobe(result_strobe),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     expected_results.size());
            $display("FAIL cubic_hermite_trajectory_sampler");
            $finish;
        end
    end

    // predictor

    function automatic longint angle_at(int w, int j);
        return longint'(angles[w % MaxWaypoints][j % MaxJoints]);
    endfunction

    function automatic longint tangent_span(int idx, int j);
        int nw;
        int prev;
        int nxt;
        nw = int'(n_waypoints);
        if (!loop_on && (idx == 0 || idx + 1 >= nw))
            return 0;
        prev = idx > 0 ? idx - 1 : (loop_on ? nw - 1 : 0);
        nxt  = idx + 1 < nw ? idx + 1 : (loop_on ? 0 : nw - 1);
        return angle_at(nxt, j) - angle_at(prev, j);
    endfunction

    function automatic longint clamp_signed(bit neg, longint unsigned mag);
        longint unsigned cap;
        cap = 64'd1 << 62;
        if (mag > cap)
            mag = cap;
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint div_toward_zero(longint num, longint unsigned den);
        longint unsigned mag;
        mag = (num < 0) ? longint'(-num) : num;
        return clamp_signed(num < 0, mag / den);
    endfunction

    function automatic longint scaled_div(longint num, longint unsigned den);
        longint unsigned mag;
        mag = (num < 0) ? longint'(-num) : num;
        if (mag >= (64'd1 << (63 - FracBits)))
            return clamp_signed(num < 0, 64'd1 << 62);
        return clamp_signed(num < 0, (mag << FracBits) / den);
    endfunction

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic void compute_results(cmd_t c);
        result_t        r;
        longint unsigned d;
        longint unsigned t;
        longint unsigned nseg;
        longint unsigned total;
        longint unsigned seg;
        longint unsigned loc;
        longint unsigned pp;
        longint         one;
        longint         p, p2, p3;
        longint         h00, h10, h01, h11, g00, g10, g11, k00, k10, k11;
        longint         q0, q1, a0, a1, sp, sv, sa;
        int             nxt;
        int             nj;
        int             nw;
        one = 64'sd1 << FracBits;
        nj = int'(n_joints);
        nw = int'(n_waypoints);
        fresh_results.delete();
        if (c.action == ActLoad)
        begin
            r = '{status: StOk, joint: c.joint_index, position: 0, velocity: 0,
                  acceleration: 0, last: 1'b1};
            if (int'(c.waypoint_index) >= nw)
                r.status = StRange;
            else if (int'(c.joint_index) < nj && int'(c.joint_index) < MaxJoints)
                angles[c.waypoint_index][c.joint_index] = c.angle;
            fresh_results.push_back(r);
            return;
        end
        if (nj == 0 || nj > MaxJoints || nw < 2 || nw > MaxWaypoints || seg_dur == 0)
        begin
            fresh_results.push_back('{status: StInvalid, joint: 3'd0, position: 0,
                                      velocity: 0, acceleration: 0, last: 1'b1});
            return;
        end
        d     = {32'd0, seg_dur};
        t     = c.sample_time[31] ? 64'd0 : {33'd0, c.sample_time[30:0]};
        nseg  = loop_on ? nw : nw - 1;
        total = d * nseg;
        if (loop_on)
            t = t % total;
        else if (t >= total)
        begin
            for (int j = 0; j < nj; j++)
                fresh_results.push_back('{status: StOk, joint: j[2:0],
                                          position: sat32(angle_at(nw - 1, j)),
                                          velocity: 0, acceleration: 0,
                                          last: j + 1 == nj});
            return;
        end
        seg = t / d;
        if (seg >= nseg)
            seg = nseg - 1;
        nxt = loop_on ? int'((seg + 1) % nw) : int'(seg + 1);
        loc = t - seg * d;
        pp  = (loc << FracBits) / d;
        if (pp > one)
            pp = one;
        p   = pp;
        p2  = (p * p) >>> FracBits;
        p3  = (p2 * p) >>> FracBits;
        h00 = 2 * p3 - 3 * p2 + one;
        h10 = p3 - 2 * p2 + p;
        h01 = 3 * p2 - 2 * p3;
        h11 = p3 - p2;
        g00 = 6 * p2 - 6 * p;
        g10 = 3 * p2 - 4 * p + one;
        g11 = 3 * p2 - 2 * p;
        k00 = 12 * p - 6 * one;
        k10 = 6 * p - 4 * one;
        k11 = 6 * p - 2 * one;
        for (int j = 0; j < nj; j++)
        begin
            q0 = angle_at(int'(seg), j);
            q1 = angle_at(nxt, j);
            a0 = tangent_span(int'(seg), j);
            a1 = tangent_span(nxt, j);
            sp = 2 * (h00 * q0 + h01 * q1) + h10 * a0 + h11 * a1;
            sv = 2 * (g00 * (q0 - q1)) + g10 * a0 + g11 * a1;
            sa = 2 * (k00 * (q0 - q1)) + k10 * a0 + k11 * a1;
            fresh_results.push_back('{status: StOk, joint: j[2:0],
                position: sat32(sp >>> (FracBits + 1)),
                velocity: sat32(div_toward_zero(sv, 2 * d)),
                acceleration: sat32(scaled_div(div_toward_zero(sa, 2 * d), d)),
                last: j + 1 == nj});
        end
    endfunction

    // checking

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got %p", $time, result);
            end
            else
            begin
                result_t e;
                e = expected_results.pop_front();
                n_checked++;
                check_field("status", e.status, result.status);
                check_field("joint", e.joint, result.joint);
                check_field("position", e.position, result.position);
                check_field("velocity", e.velocity, result.velocity);
                check_field("acceleration", e.acceleration, result.acceleration);
                check_field("last", e.last, result.last);
            end
        end
    end

    // stimulus

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CfgJointCount:    n_joints    = data[2:0];
            CfgWaypointCount: n_waypoints = data[4:0];
            CfgSegDuration:   seg_dur     = data;
            default:          loop_on     = data[0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_results.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_item(cmd_t c, bit typed, result_t typed_r);
        int gap;
        gap = bursty ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        compute_results(c);
        if (c.action == ActLoad)
            n_loads++;
        else
            n_samples++;
        if (typed)
            expected_results.push_back(typed_r);
        else
            foreach (fresh_results[i])
                expected_results.push_back(fresh_results[i]);
    endtask

    function automatic void plan_cfg(logic [1:0] idx, logic [31:0] data);
        plan_row_t row;
        row = '{is_cfg: 1'b1, reg_index: idx, reg_data: data, item: '0,
                typed: 1'b0, typed_result: '0};
        plan.push_back(row);
    endfunction

    function automatic void plan_load(int w, int j, logic [31:0] a, logic [1:0] st);
        plan_row_t row;
        row = '{is_cfg: 1'b0, reg_index: '0, reg_data: '0,
                item: '{action: ActLoad, waypoint_index: w[3:0], joint_index: j[2:0],
                        angle: a, sample_time: 32'h1234_5678},
                typed: 1'b1,
                typed_result: '{status: st, joint: j[2:0], position: 0, velocity: 0,
                                acceleration: 0, last: 1'b1}};
        plan.push_back(row);
    endfunction

    function automatic void plan_sample(logic [31:0] t, bit bad);
        plan_row_t row;
        row = '{is_cfg: 1'b0, reg_index: '0, reg_data: '0,
                item: '{action: ActSample, waypoint_index: 4'hf, joint_index: 3'd7,
                        angle: 32'hdead_beef, sample_time: t},
                typed: bad,
                typed_result: '{status: StInvalid, joint: 3'd0, position: 0, velocity: 0,
                                acceleration: 0, last: 1'b1}};
        plan.push_back(row);
    endfunction

    function automatic cmd_t random_item();
        cmd_t           c;
        int             nw;
        longint unsigned span;
        nw = (n_waypoints >= 1 && n_waypoints <= MaxWaypoints) ? int'(n_waypoints)
                                                                : MaxWaypoints;
        c.action = ($urandom_range(0, 99) < 62) ? ActLoad : ActSample;
        c.waypoint_index = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, nw - 1))
                                                       : 4'($urandom_range(0, 15));
        c.joint_index = ($urandom_range(0, 9) < 8 && n_joints >= 1 && n_joints <= 6)
                        ? 3'($urandom_range(0, n_joints - 1)) : 3'($urandom_range(0, 7));
        c.angle = ($urandom_range(0, 3) == 0) ? $urandom
                  : $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
        span = {32'd0, seg_dur} * (loop_on ? nw : nw - 1) * 5 / 4 + 1;
        if (span > 64'h7fff_ffff)
            span = 64'h7fff_ffff;
        c.sample_time = ($urandom_range(0, 3) == 0) ? $urandom
                        : $urandom_range(0, 32'(span));
        return c;
    endfunction

    initial
    begin
        n_loads     = 0;
        n_samples   = 0;
        bursty      = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        foreach (angles[w, j])
            angles[w][j] = 0;
        n_joints    = 3'd6;
        n_waypoints = 5'd2;
        seg_dur     = 32'd65536;
        loop_on     = 1'b0;

        plan_sample(32'd0, 1'b0);
        plan_load(0, 0, 32'h7fff_ffff, StOk);
        plan_load(1, 5, 32'h8000_0000, StOk);
        plan_load(2, 1, 32'h0001_0000, StRange);
        plan_load(15, 7, 32'hffff_ffff, StRange);
        plan_load(0, 6, 32'h0005_0000, StOk);
        plan_load(1, 0, 32'hffff_0000, StOk);
        plan_load(0, 3, 32'h0003_0000, StOk);
        plan_sample(32'd32768, 1'b0);
        plan_sample(32'd65535, 1'b0);
        plan_sample(32'd65536, 1'b0);
        plan_sample(32'h7fff_ffff, 1'b0);
        plan_sample(32'h8000_0000, 1'b0);
        plan_cfg(CfgLoopMode, 32'd1);
        plan_sample(32'd100000, 1'b0);
        plan_sample(32'h7fff_ffff, 1'b0);
        plan_cfg(CfgSegDuration, 32'd0);
        plan_sample(32'd10, 1'b1);
        plan_cfg(CfgSegDuration, 32'd1);
        plan_sample(32'd5, 1'b0);
        plan_cfg(CfgWaypointCount, 32'd16);
        plan_cfg(CfgJointCount, 32'd1);
        plan_cfg(CfgSegDuration, 32'hffff_ffff);
        plan_load(15, 0, 32'h7fff_ffff, StOk);
        plan_sample(32'h7fff_ffff, 1'b0);
        plan_cfg(CfgLoopMode, 32'd0);
        plan_sample(32'h7fff_ffff, 1'b0);
        plan_cfg(CfgJointCount, 32'd0);
        plan_sample(32'd0, 1'b1);
        plan_cfg(CfgJointCount, 32'd7);
        plan_sample(32'd0, 1'b1);
        plan_cfg(CfgJointCount, 32'd6);
        plan_cfg(CfgWaypointCount, 32'd1);
        plan_sample(32'd0, 1'b1);
        plan_cfg(CfgWaypointCount, 32'd17);
        plan_sample(32'd0, 1'b1);
        plan_load(15, 2, 32'h0000_8000, StOk);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_idle();
                write_reg(plan[i].reg_index, plan[i].reg_data);
            end
            else
                send_item(plan[i].item, plan[i].typed, plan[i].typed_result);
        end

        for (int ph = 0; ph < Phases; ph++)
        begin
            logic [31:0] jc, wc, dur;
            wait_idle();
            bursty = ph % 3 == 1;
            jc = ($urandom_range(0, 19) == 0) ? ($urandom_range(0, 1) ? 0 : 7)
                 : (ph == 0 ? 1 : ph == 1 ? 6 : $urandom_range(1, 6));
            wc = ($urandom_range(0, 19) == 0) ? ($urandom_range(0, 1) ? 1 : 31)
                 : (ph == 0 ? 2 : ph == 1 ? 16 : $urandom_range(2, 16));
            case ($urandom_range(0, 9))
                0:       dur = 32'd1;
                1:       dur = 32'hffff_ffff;
                2:       dur = ph == 5 ? 32'd0 : 32'd65536;
                default: dur = $urandom_range(32'h1000, 32'h10_0000);
            endcase
            write_reg(CfgJointCount, jc);
            write_reg(CfgWaypointCount, wc);
            write_reg(CfgSegDuration, dur);
            write_reg(CfgLoopMode, ph % 2);
            repeat (PerPhase)
                send_item(random_item(), 1'b0, '0);
        end

        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d loads and %0d samples, %0d results checked, %0d errors",
                 n_loads, n_samples, n_checked, errors);
        $display("config settings varied across %0d random phases and directed edges",
                 Phases);
        if (errors == 0)
            $display("PASS cubic_hermite_trajectory_sampler");
        else
            $display("FAIL cubic_hermite_trajectory_sampler");
        $finish;
    end

endmodule
